// ===== sv/assert_macros.svh =====
// Assertion macros used by the RTL of the temperature linearizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr)
`define ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif
`endif

// ===== sv/stl_pkg.sv =====
// Types, constants and the gain table of the temperature linearizer.
package stl_pkg;

  localparam int RAD_PAIRS = 17;
  localparam int RAD_W = 2 * RAD_PAIRS;
  localparam int PROD_W = 27;
  localparam int SCALED_W = 17;
  localparam int RECIP_SHIFT = 37;
  localparam logic [27:0] RECIP_1000 = 28'd137438954;
  localparam int DIV_STEPS = 10;
  localparam int DV_W = 26;
  localparam logic [16:0] RECIP_10 = 17'd52429;
  localparam int RECIP_10_SHIFT = 19;
  localparam int T_HIGH_TENTHS = 900;
  localparam int T_LOW_TENTHS = -430;
  localparam logic [6:0] T_HIGH_DEG = 7'd90;
  localparam logic [5:0] T_LOW_DEG_MAG = 6'd43;

  localparam logic [2:0] REG_COEF_A = 3'd0;
  localparam logic [2:0] REG_COEF_B = 3'd1;
  localparam logic [2:0] REG_COEF_C = 3'd2;
  localparam logic [2:0] REG_COEF_D = 3'd3;
  localparam logic [2:0] REG_COEF_E = 3'd4;
  localparam logic [2:0] REG_USER_OFFSET = 3'd5;
  localparam logic [2:0] REG_BANDGAP_TRIM = 3'd6;

  // Result control that rides along with the final divide.
  typedef struct packed {
    logic clamped;
    logic sat;
    logic neg;
    logic signed [10:0] sat_tenths;
  } fin_t;

  function automatic logic [10:0] gain_lookup(input logic [4:0] idx);
    logic [10:0] g;
    case (idx)
      5'd0: g = 11'h3E5;  5'd1: g = 11'h3E8;  5'd2: g = 11'h3EC;  5'd3: g = 11'h3EF;
      5'd4: g = 11'h3D9;  5'd5: g = 11'h3DC;  5'd6: g = 11'h3E0;  5'd7: g = 11'h3E3;
      5'd8: g = 11'h3D3;  5'd9: g = 11'h3D6;  5'd10: g = 11'h3D9; 5'd11: g = 11'h3DC;
      5'd12: g = 11'h3C6; 5'd13: g = 11'h3C9; 5'd14: g = 11'h3CC; 5'd15: g = 11'h3CF;
      5'd16: g = 11'h410; 5'd17: g = 11'h413; 5'd18: g = 11'h416; 5'd19: g = 11'h419;
      5'd20: g = 11'h403; 5'd21: g = 11'h407; 5'd22: g = 11'h40A; 5'd23: g = 11'h40D;
      5'd24: g = 11'h3FA; 5'd25: g = 11'h3FD; 5'd26: g = 11'h400; 5'd27: g = 11'h403;
      5'd28: g = 11'h3ED; 5'd29: g = 11'h3F1; 5'd30: g = 11'h3F4; 5'd31: g = 11'h3F7;
      default: g = 11'h3E5;
    endcase
    return g;
  endfunction

endpackage

// ===== sv/sensor_temperature_linearizer_unit.sv =====
// Top level of the temperature linearizer: a fully pipelined datapath.
//
// Usage: a raw sample word enters on in_adc_sample with in_valid; it is taken
// at a clock edge where in_valid is high and in_stall is low. One result word
// per sample leaves on out_temperature_tenths / out_clamped with out_valid and
// is taken when out_stall is low.
// Coefficients are written through cfg_we / cfg_index / cfg_wdata while no
// sample is in flight.
// The square root resolves one result bit per pipeline stage, and the final
// divide resolves one quotient bit per stage.
// Throughput is one word per cycle while out_stall is low. When out_stall is
// high the last stage holds its word; empty stages further back still fill,
// and in_stall rises only once every stage holds a word.
// A synchronous reset (rst_n low) empties the pipeline and loads the default
// coefficients.
module sensor_temperature_linearizer_unit
  import stl_pkg::*;
#(
  parameter int ROOT_FRAC_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [15:0]         in_adc_sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [10:0]  out_temperature_tenths,
  output logic                out_clamped,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);

  `include "assert_macros.svh"

  localparam int RW = RAD_PAIRS + ROOT_FRAC_BITS;
  localparam int REM_W = RW + 3;
  localparam int TW = RW + 19;
  localparam int P_SQ0 = 3;
  localparam int P_NUM = P_SQ0 + RW;
  localparam int P_TOT = P_NUM + 1;
  localparam int P_CMP = P_NUM + 2;
  localparam int P_DIV0 = P_NUM + 3;
  localparam int P_OUT = P_DIV0 + DIV_STEPS;
  localparam int NS = P_OUT + 1;

  // Configuration registers.
  logic [31:0] coef_a_r, coef_c_r;
  logic [15:0] coef_b_r, coef_d_r, coef_e_r;
  logic [15:0] user_offset_r;
  logic [4:0]  bandgap_trim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r       <= 32'd18018;
      coef_b_r       <= 16'd1;
      coef_c_r       <= 32'd224019254;
      coef_d_r       <= 16'd7092;
      coef_e_r       <= 16'd10;
      user_offset_r  <= 16'd0;
      bandgap_trim_r <= 5'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COEF_A:       coef_a_r       <= cfg_wdata;
        REG_COEF_B:       coef_b_r       <= cfg_wdata[15:0];
        REG_COEF_C:       coef_c_r       <= cfg_wdata;
        REG_COEF_D:       coef_d_r       <= cfg_wdata[15:0];
        REG_COEF_E:       coef_e_r       <= cfg_wdata[15:0];
        REG_USER_OFFSET:  user_offset_r  <= cfg_wdata[15:0];
        REG_BANDGAP_TRIM: bandgap_trim_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // Values derived from the configuration, refreshed every cycle.
  logic [15:0]          ofs_mag;
  logic [32:0]          ofs_quot;
  logic signed [12:0]   ofs_r;
  logic signed [TW-1:0] ofsden_r, hi_r, lo_r;
  logic signed [29:0]   ofsden_prod;

  always_comb begin
    ofs_mag = user_offset_r[15] ? 16'(-user_offset_r) : user_offset_r;
    ofs_quot = 33'(ofs_mag) * 33'(RECIP_10);
    ofsden_prod = 30'(ofs_r) * $signed({1'b0, coef_e_r});
  end

  always_ff @(posedge clk) begin
    ofs_r <= user_offset_r[15] ? -13'(ofs_quot[32:RECIP_10_SHIFT])
                               : 13'(ofs_quot[32:RECIP_10_SHIFT]);
    ofsden_r <= TW'(ofsden_prod) <<< ROOT_FRAC_BITS;
    hi_r <= $signed(TW'({7'd0, coef_e_r} * 23'(T_HIGH_DEG))) <<< ROOT_FRAC_BITS;
    lo_r <= -($signed(TW'({6'd0, coef_e_r} * 22'(T_LOW_DEG_MAG))) <<< ROOT_FRAC_BITS);
  end

  // Stage advance: a stage moves when it is empty or the stage after moves.
  logic [NS-1:0] v_r;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || !out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= (k == 0) ? in_valid : v_r[k-1 < 0 ? 0 : k-1];
        end
      end
    end
  end

  assign in_stall = !en[0];

  // Gain scale, divide by 1000 by reciprocal, then form the radicand.
  logic [PROD_W-1:0]   prod_r;
  logic [SCALED_W-1:0] scaled_r;
  logic [RAD_W-1:0]    rad_r;
  logic [54:0]         recip_prod;

  assign recip_prod = 55'(prod_r) * 55'(RECIP_1000);

  always_ff @(posedge clk) begin
    if (en[0]) prod_r <= PROD_W'(in_adc_sample) * PROD_W'(gain_lookup(bandgap_trim_r));
    if (en[1]) scaled_r <= SCALED_W'(recip_prod >> RECIP_SHIFT);
    if (en[2]) rad_r <= RAD_W'(coef_c_r) + RAD_W'(coef_d_r) * RAD_W'(scaled_r);
  end

  // Square root, one result bit per stage.
  logic [RAD_W-1:0] sq_rad_r [RW];
  logic [REM_W-1:0] sq_rem_r [RW];
  logic [RW-1:0]    sq_root_r [RW];

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    localparam int I = RW - 1 - k;
    logic [RAD_W-1:0] rad_in;
    logic [REM_W-1:0] rem_in, rem_sh, trial, rem_nxt;
    logic [RW-1:0]    root_in, root_nxt;
    logic [1:0]       pair;

    if (k == 0) begin : g_first
      assign rad_in  = rad_r;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_rest
      assign rad_in  = sq_rad_r[k-1];
      assign rem_in  = sq_rem_r[k-1];
      assign root_in = sq_root_r[k-1];
    end

    if (I >= ROOT_FRAC_BITS) begin : g_pair
      assign pair = rad_in[2*(I-ROOT_FRAC_BITS) +: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    always_comb begin
      rem_sh = {rem_in[REM_W-3:0], pair};
      trial  = REM_W'({root_in, 2'b01});
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_in[RW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_in[RW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en[P_SQ0+k]) begin
        sq_rad_r[k]  <= rad_in;
        sq_rem_r[k]  <= rem_nxt;
        sq_root_r[k] <= root_nxt;
      end
    end
  end

  // Numerator, offset, limit compare.
  logic signed [TW-1:0] num_r, total_r;
  logic [TW+3:0]        mag10;
  logic [TW-1:0]        mag;
  logic [DV_W-1:0]      dv_nxt;
  fin_t                 fin_nxt;
  logic [DV_W-1:0]      dv_r [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] q_r [DIV_STEPS+1];
  fin_t                 fin_r [DIV_STEPS+1];

  always_comb begin
    mag = total_r[TW-1] ? TW'(-total_r) : TW'(total_r);
    mag10 = {mag, 3'b000} + {2'b00, mag, 1'b0};
    dv_nxt = DV_W'(mag10 >> ROOT_FRAC_BITS);
    fin_nxt.neg = total_r[TW-1];
    fin_nxt.sat = 1'b1;
    fin_nxt.clamped = 1'b1;
    fin_nxt.sat_tenths = 11'(T_HIGH_TENTHS);
    if (coef_e_r == '0) begin
      // The offset term is zero here, so total equals the numerator.
      if (total_r < 0) begin
        fin_nxt.sat_tenths = 11'(T_LOW_TENTHS);
      end else if (total_r == 0) begin
        fin_nxt.sat_tenths = '0;
      end
    end else if (total_r > hi_r) begin
      fin_nxt.sat_tenths = 11'(T_HIGH_TENTHS);
    end else if (total_r < lo_r) begin
      fin_nxt.sat_tenths = 11'(T_LOW_TENTHS);
    end else begin
      fin_nxt.sat = 1'b0;
      fin_nxt.clamped = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[P_NUM]) begin
      num_r <= $signed(TW'(coef_b_r) * TW'(sq_root_r[RW-1]))
             - $signed(TW'({coef_a_r, {ROOT_FRAC_BITS{1'b0}}}));
    end
    if (en[P_TOT]) total_r <= num_r + ofsden_r;
    if (en[P_CMP]) begin
      dv_r[0]  <= dv_nxt;
      q_r[0]   <= '0;
      fin_r[0] <= fin_nxt;
    end
  end

  // Divide by coef_e, one quotient bit per stage; the 2^F part of the
  // denominator was already shifted out of the dividend.
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    localparam int B = DIV_STEPS - 1 - s;
    logic [DV_W-1:0] dcmp;
    assign dcmp = DV_W'(coef_e_r) << B;
    always_ff @(posedge clk) begin
      if (en[P_DIV0+s]) begin
        fin_r[s+1] <= fin_r[s];
        if (dv_r[s] >= dcmp) begin
          dv_r[s+1] <= dv_r[s] - dcmp;
          q_r[s+1]  <= q_r[s] | (DIV_STEPS'(1) << B);
        end else begin
          dv_r[s+1] <= dv_r[s];
          q_r[s+1]  <= q_r[s];
        end
      end
    end
  end

  logic signed [10:0] tenths_r;
  logic               clamped_r;

  always_ff @(posedge clk) begin
    if (en[P_OUT]) begin
      clamped_r <= fin_r[DIV_STEPS].clamped;
      if (fin_r[DIV_STEPS].sat) begin
        tenths_r <= fin_r[DIV_STEPS].sat_tenths;
      end else if (fin_r[DIV_STEPS].neg) begin
        tenths_r <= -11'(q_r[DIV_STEPS]);
      end else begin
        tenths_r <= 11'(q_r[DIV_STEPS]);
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_temperature_tenths = tenths_r;
  assign out_clamped = clamped_r;

  `ASSERT_IMPLIES(a_in_range, clk, rst_n, out_valid, (out_temperature_tenths >= -11'sd430) && (out_temperature_tenths <= 11'sd900))
  `ASSERT_IMPLIES(a_clamp_value, clk, rst_n, out_valid && out_clamped && (coef_e_r != '0), (out_temperature_tenths == 11'sd900) || (out_temperature_tenths == -11'sd430))
  `ASSERT_IMPLIES(a_stall_full, clk, rst_n, in_stall, v_r[0] && out_valid && out_stall)
  `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_temperature_tenths))

endmodule
